### rtl/kmt_pkg.sv
// ----------------------------------------------------------------------------
// kmt_pkg: shared types and constants of the keyed mutex table
// Request and result structs, function and status codes, controller states.
// ----------------------------------------------------------------------------
package kmt_pkg;

  typedef enum logic [1:0] {
    FN_INIT    = 2'd0,
    FN_ACQUIRE = 2'd1,
    FN_RELEASE = 2'd2,
    FN_CLEANUP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_GRANTED   = 3'd1,
    ST_WAIT      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_UNINIT    = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  localparam logic [15:0] NO_OWNER = 16'hFFFF;
  localparam int unsigned WAKE_CAP = 16;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] lock_key;
    logic [7:0]         lock_index;
    logic [14:0]        proc_id;
    logic [3:0]         proc_slot;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] lock_id;
    logic       wake_waiters;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_FREE,
    S_SINGLE,
    S_CLEAN,
    S_FINAL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic clr_idx;   // restart the scan index
    logic step;      // advance the scan index
    logic do_match;  // key match step at the current index
    logic do_free;   // free entry step at the current index
    logic do_single; // acquire or release
    logic do_clean;  // cleanup step at the current index
    logic do_final;  // emit the final result of an init or cleanup
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       func_init;
    logic       func_cleanup;
    logic       idx_last;  // scan index is at the last entry
    logic       hit;       // match or free entry found at the current index
  } stat_t;

endpackage

### rtl/kmt_ctrl.sv
// ----------------------------------------------------------------------------
// kmt_ctrl: controller of the keyed mutex table
// Sequences the scans of init and cleanup and the single step operations.
// ----------------------------------------------------------------------------
module kmt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kmt_pkg::stat_t stat,
  output kmt_pkg::cmd_t  cmd,
  output logic           busy
);
  import kmt_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next  = S_SINGLE;
        end
      end
      S_SINGLE: begin
        if (stat.func_init) begin
          state_next = S_MATCH;
        end else if (stat.func_cleanup) begin
          state_next = S_CLEAN;
        end else begin
          cmd.do_single = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_MATCH: begin
        cmd.do_match = 1'b1;
        if (stat.hit) begin
          state_next = S_IDLE;
        end else if (stat.idx_last) begin
          cmd.clr_idx = 1'b1;
          state_next  = S_FREE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.do_free = 1'b1;
        if (stat.hit)          state_next = S_IDLE;
        else if (stat.idx_last) state_next = S_FINAL;
        else                    cmd.step   = 1'b1;
      end
      S_CLEAN: begin
        cmd.do_clean = 1'b1;
        if (stat.idx_last) state_next = S_FINAL;
        else               cmd.step   = 1'b1;
      end
      S_FINAL: begin
        cmd.do_final = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Scan commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_match, cmd.do_free, cmd.do_single, cmd.do_clean, cmd.do_final}))
    else $error("kmt_ctrl: overlapping commands");
  // A request is only loaded while idle.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy) else $error("kmt_ctrl: load while busy");
  // A free scan follows only a match scan.
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE && $past(state) != S_FREE) |-> $past(state) == S_MATCH)
    else $error("kmt_ctrl: free scan out of order");

endmodule

### rtl/kmt_dp.sv
// ----------------------------------------------------------------------------
// kmt_dp: datapath of the keyed mutex table
// Holds the lock entries and the scan index and forms the results.
// ----------------------------------------------------------------------------
module kmt_dp #(
  parameter int LOCK_COUNT = 16,
  parameter int PROC_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  kmt_pkg::req_t req,
  input  kmt_pkg::cmd_t cmd,
  output kmt_pkg::stat_t stat,
  output kmt_pkg::rsp_t result,
  output logic          result_valid
);
  import kmt_pkg::*;

  localparam int IW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;

  logic [31:0] entry_key   [LOCK_COUNT];
  logic [15:0] user_bitmap [LOCK_COUNT];
  logic        held_flag   [LOCK_COUNT];
  logic [15:0] owner_pid   [LOCK_COUNT];

  req_t        r;
  logic [IW-1:0] idx;
  logic [4:0]  wake_n;
  logic [15:0] bit_mask;
  logic [IW-1:0] sel;
  logic        in_range;
  logic [15:0] cur_bm;
  logic [15:0] bm_cleared;
  logic        rel_hit;
  logic        touched;

  // Slot bit; slots beyond the bitmap name no bit.
  always_comb begin
    bit_mask = '0;
    if (32'(r.proc_slot) < 32'(PROC_SLOTS)) bit_mask[r.proc_slot] = 1'b1;
  end

  // Entry chosen by the scan or by the request index.
  assign in_range = ({24'd0, r.lock_index} < 32'(LOCK_COUNT));
  assign sel      = cmd.do_single ? r.lock_index[IW-1:0] : idx;
  assign cur_bm   = user_bitmap[sel];
  assign bm_cleared = cur_bm & ~bit_mask;
  assign rel_hit  = (cur_bm != 0) && held_flag[sel] && (owner_pid[sel] == {1'b0, r.proc_id});
  assign touched  = rel_hit || (((cur_bm & bit_mask) != 0) && (bm_cleared == 0));

  // Status toward the controller.
  always_comb begin
    stat.func_init    = (r.func == FN_INIT);
    stat.func_cleanup = (r.func == FN_CLEANUP);
    stat.idx_last     = (32'(idx) == 32'(LOCK_COUNT - 1));
    stat.hit          = cmd.do_match ? ((cur_bm != 0) && (entry_key[idx] == r.lock_key))
                                     : (cur_bm == 0);
  end

  // Request register and scan index.
  always_ff @(posedge clk) begin
    if (cmd.load) r <= req;
    if (rst || cmd.clr_idx) idx <= '0;
    else if (cmd.step)      idx <= idx + 1'b1;
    if (rst || cmd.load)    wake_n <= '0;
    else if (cmd.do_clean && touched && wake_n < 5'(WAKE_CAP)) wake_n <= wake_n + 5'd1;
  end

  // Entry updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOCK_COUNT; i++) begin
        user_bitmap[i] <= '0;
        held_flag[i]   <= 1'b0;
        owner_pid[i]   <= '0;
      end
    end else if ((cmd.do_match || cmd.do_free) && stat.hit) begin
      user_bitmap[sel] <= cur_bm | bit_mask;
      if (cmd.do_free) begin
        held_flag[sel] <= 1'b0;
        owner_pid[sel] <= NO_OWNER;
      end
    end else if (cmd.do_single && in_range) begin
      if (r.func == FN_ACQUIRE) begin
        if (!held_flag[sel]) begin
          held_flag[sel] <= 1'b1;
          owner_pid[sel] <= {1'b0, r.proc_id};
        end
      end else if (cur_bm != 0 && owner_pid[sel] == {1'b0, r.proc_id}) begin
        held_flag[sel] <= 1'b0;
      end
    end else if (cmd.do_clean) begin
      // Only a released lock or one that just lost its last user drops its flag.
      if (touched) held_flag[sel] <= 1'b0;
      user_bitmap[sel] <= bm_cleared;
    end
  end

  // Keys have no reset.
  always_ff @(posedge clk) begin
    if (cmd.do_free && stat.hit) entry_key[sel] <= r.lock_key;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= ((cmd.do_match || cmd.do_free) && stat.hit) || cmd.do_single ||
                         cmd.do_final || (cmd.do_clean && touched && wake_n < 5'(WAKE_CAP));
    result.wake_waiters <= 1'b0;
    result.last         <= 1'b1;
    result.lock_id      <= 4'(sel);
    result.status       <= ST_DONE;
    if (cmd.do_final) begin
      result.lock_id <= '0;
      result.status  <= stat.func_init ? ST_FULL : ST_DONE;
    end else if (cmd.do_clean) begin
      result.wake_waiters <= 1'b1;
      result.last         <= 1'b0;
    end else if (cmd.do_single) begin
      result.lock_id <= r.lock_index[3:0];
      if (!in_range)                            result.status <= ST_RANGE;
      else if (r.func == FN_ACQUIRE)            result.status <= held_flag[sel] ? ST_WAIT
                                                                                : ST_GRANTED;
      else if (cur_bm == 0)                     result.status <= ST_UNINIT;
      else if (owner_pid[sel] != {1'b0, r.proc_id}) result.status <= ST_NOT_OWNER;
      else                                      result.wake_waiters <= 1'b1;
    end
  end

  // Wake results never exceed the cap.
  a_wake_cap: assert property (@(posedge clk) disable iff (rst)
    wake_n <= 5'(WAKE_CAP)) else $error("kmt_dp: wake count overflow");
  // A non-final result carries a wake.
  a_wake_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> result.wake_waiters)
    else $error("kmt_dp: bad wake result");
  // The request stays put while a scan runs.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_clean && $past(cmd.do_clean)) |-> $stable(r))
    else $error("kmt_dp: request changed in a scan");

endmodule

### rtl/keyed_mutex_table_top.sv
// ----------------------------------------------------------------------------
// keyed_mutex_table_top: keyed mutex table
// Acquire and release are single steps; init scans the table for a matching key,
// then for a free entry, and cleanup scans it once, one entry per cycle.
// Results appear in the cycle after the step making them; one request at a time.
// Synchronous reset clears bitmaps, held flags and owners; keys stay undefined.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module keyed_mutex_table_top #(
  parameter int LOCK_COUNT = 16,
  parameter int PROC_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  kmt_pkg::req_t request,
  output logic          busy,
  output logic          strobe,
  output kmt_pkg::rsp_t result
);
  import kmt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  kmt_ctrl u_ctrl (.clk, .rst, .start, .stat, .cmd, .busy);

  // Datapath.
  kmt_dp #(.LOCK_COUNT(LOCK_COUNT), .PROC_SLOTS(PROC_SLOTS)) u_dp (
    .clk, .rst, .req(request), .cmd, .stat, .result, .result_valid(strobe));

endmodule

### sim/keyed_mutex_table_top_tb.sv
// ----------------------------------------------------------------------------
// keyed_mutex_table_top_tb: self-checking bench for the keyed mutex table
// Directed requests cover the field extremes, every function and the full
// table, then well-formed random traffic follows. A local model of the lock
// table predicts every result, and a monitor compares each strobed result
// field by field.
// ----------------------------------------------------------------------------
module keyed_mutex_table_top_tb;
  import kmt_pkg::*;

  localparam int LOCKS   = 16;
  localparam int PERIOD  = 12;
  localparam int N_RAND  = 216;

  // One slot of the stimulus queue: a request, or a pause until all results arrive.
  typedef struct {
    bit   drain;
    req_t req;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic strobe;
  rsp_t result;

  stim_t stim_q[$];
  rsp_t  due_results[$];
  int    errors = 0;
  int    accepted = 0;
  bit    stim_done = 1'b0;

  // Shadow copy of the lock table.
  logic [31:0] key_tab[LOCKS];
  logic [15:0] user_map[LOCKS];
  logic        held[LOCKS];
  logic [15:0] owner[LOCKS];

  keyed_mutex_table_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #(PERIOD / 2) clk = 1'b1;
    #(PERIOD / 2) clk = 1'b0;
  end

  function automatic rsp_t make_rsp(status_t st, int id, bit wake, bit fin);
    rsp_t r;
    r.status = st;
    r.lock_id = id[3:0];
    r.wake_waiters = wake;
    r.last = fin;
    return r;
  endfunction

  // Apply one accepted request to the shadow table and queue its results.
  function automatic void apply_request(req_t r);
    int id;
    int n;
    bit touched;
    logic [15:0] sbit;
    sbit = 16'd1 << r.proc_slot;
    case (r.func)
      FN_INIT: begin
        id = -1;
        for (int i = 0; i < LOCKS; i++)
          if (id < 0 && user_map[i] != 0 && key_tab[i] == r.lock_key) id = i;
        for (int i = 0; i < LOCKS; i++)
          if (id < 0 && user_map[i] == 0) begin
            held[i] = 1'b0;
            owner[i] = NO_OWNER;
            key_tab[i] = r.lock_key;
            id = i;
          end
        if (id < 0) begin
          due_results.push_back(make_rsp(ST_FULL, 0, 1'b0, 1'b1));
        end else begin
          user_map[id] |= sbit;
          due_results.push_back(make_rsp(ST_DONE, id, 1'b0, 1'b1));
        end
      end
      FN_ACQUIRE, FN_RELEASE: begin
        id = r.lock_index;
        if (r.lock_index >= LOCKS) begin
          due_results.push_back(make_rsp(ST_RANGE, id, 1'b0, 1'b1));
        end else if (r.func == FN_ACQUIRE) begin
          if (!held[id]) begin
            held[id] = 1'b1;
            owner[id] = {1'b0, r.proc_id};
            due_results.push_back(make_rsp(ST_GRANTED, id, 1'b0, 1'b1));
          end else begin
            due_results.push_back(make_rsp(ST_WAIT, id, 1'b0, 1'b1));
          end
        end else if (user_map[id] == 0) begin
          due_results.push_back(make_rsp(ST_UNINIT, id, 1'b0, 1'b1));
        end else if (owner[id] != {1'b0, r.proc_id}) begin
          due_results.push_back(make_rsp(ST_NOT_OWNER, id, 1'b0, 1'b1));
        end else begin
          held[id] = 1'b0;
          due_results.push_back(make_rsp(ST_DONE, id, 1'b1, 1'b1));
        end
      end
      default: begin
        n = 0;
        for (int i = 0; i < LOCKS; i++) begin
          touched = 1'b0;
          if (user_map[i] != 0 && held[i] && owner[i] == {1'b0, r.proc_id}) begin
            held[i] = 1'b0;
            touched = 1'b1;
          end
          if ((user_map[i] & sbit) != 0) begin
            user_map[i] &= ~sbit;
            if (user_map[i] == 0) begin
              held[i] = 1'b0;
              touched = 1'b1;
            end
          end
          if (touched && n < WAKE_CAP) begin
            due_results.push_back(make_rsp(ST_DONE, i, 1'b1, 1'b0));
            n++;
          end
        end
        due_results.push_back(make_rsp(ST_DONE, 0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  function automatic void add_req(func_t f, logic [31:0] key, logic [7:0] idx,
                                  logic [14:0] pid, logic [3:0] slot);
    stim_t s;
    s.drain = 1'b0;
    s.req.func = f;
    s.req.lock_key = key;
    s.req.lock_index = idx;
    s.req.proc_id = pid;
    s.req.proc_slot = slot;
    stim_q.push_back(s);
  endfunction

  function automatic void add_drain();
    stim_t s;
    s.drain = 1'b1;
    s.req = '0;
    stim_q.push_back(s);
  endfunction

  // Random traffic: a small key and pid pool so locks collide, fill up and free.
  function automatic void add_random();
    func_t f;
    logic [31:0] key;
    logic [7:0] idx;
    logic [14:0] pid;
    int pick;
    pick = $urandom_range(0, 99);
    f = pick < 35 ? FN_INIT : pick < 60 ? FN_ACQUIRE : pick < 85 ? FN_RELEASE : FN_CLEANUP;
    key = ($urandom_range(0, 9) == 0) ? $urandom() : 32'h5000_0000 + $urandom_range(0, 19);
    idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
    pid = ($urandom_range(0, 9) == 0) ? 15'($urandom()) : 15'($urandom_range(1, 6));
    add_req(f, key, idx, pid, 4'($urandom_range(0, 15)));
  endfunction

  // Driver: hold each request until the block takes it.
  always @(posedge clk) begin
    logic nxt_start;
    req_t nxt_req;
    bit quiet;
    stim_t head;
    nxt_start = start;
    nxt_req = request;
    if (rst) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(request);
        accepted++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (stim_q.size() > 0 && stim_q[0].drain && due_results.size() == 0 && !start)
          void'(stim_q.pop_front());
        quiet = (accepted >= 80 && accepted < 150);
        if (stim_q.size() > 0 && !stim_q[0].drain &&
            (quiet || $urandom_range(0, 99) >= 21)) begin
          head = stim_q.pop_front();
          nxt_req = head.req;
          nxt_start = 1'b1;
        end
      end
    end
    start <= nxt_start;
    request <= nxt_req;
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && strobe) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d lock_id %0d", result.status, result.lock_id);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.lock_id !== want.lock_id) begin
          $error("lock_id: expected %0d, got %0d", want.lock_id, result.lock_id);
          errors++;
        end
        if (result.wake_waiters !== want.wake_waiters) begin
          $error("wake_waiters: expected %0d, got %0d", want.wake_waiters,
                 result.wake_waiters);
          errors++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          errors++;
        end
      end
    end
  end

  // Stimulus, then wait for the table to drain and report.
  initial begin
    for (int i = 0; i < LOCKS; i++) begin
      key_tab[i] = '0;
      user_map[i] = '0;
      held[i] = 1'b0;
      owner[i] = '0;
    end
    // Extremes of keys and slots, key reuse, and all acquire and release outcomes.
    add_req(FN_INIT, 32'h8000_0000, 8'd0, 15'd1, 4'd0);
    add_req(FN_INIT, 32'h7FFF_FFFF, 8'd0, 15'd2, 4'd15);
    add_req(FN_INIT, 32'h8000_0000, 8'd0, 15'd3, 4'd3);
    add_req(FN_ACQUIRE, 32'hFFFF_FFFF, 8'd0, 15'h7FFF, 4'd0);
    add_req(FN_ACQUIRE, 32'd0, 8'd0, 15'd0, 4'd0);
    add_req(FN_ACQUIRE, 32'd0, 8'd16, 15'd1, 4'd0);
    add_req(FN_RELEASE, 32'd0, 8'd255, 15'd1, 4'd0);
    add_req(FN_RELEASE, 32'd0, 8'd0, 15'd1, 4'd0);
    add_req(FN_RELEASE, 32'd0, 8'd9, 15'd1, 4'd0);
    add_req(FN_RELEASE, 32'd0, 8'd0, 15'h7FFF, 4'd0);
    add_req(FN_ACQUIRE, 32'd0, 8'd15, 15'd2, 4'd0);
    add_req(FN_ACQUIRE, 32'd0, 8'd1, 15'd2, 4'd0);
    add_req(FN_CLEANUP, 32'd0, 8'd0, 15'd2, 4'd15);
    add_req(FN_CLEANUP, 32'd0, 8'd0, 15'd9, 4'd3);
    add_req(FN_CLEANUP, 32'd0, 8'd0, 15'd9, 4'd0);
    // Fill the table with slot bits, then one init too many.
    for (int i = 0; i < LOCKS; i++)
      add_req(FN_INIT, 32'hA000_0000 + i, 8'd0, 15'd4, 4'(i % 2));
    add_req(FN_INIT, 32'h0000_0001, 8'd0, 15'd4, 4'd5);
    add_drain();
    add_req(FN_CLEANUP, 32'd0, 8'd0, 15'd4, 4'd0);
    add_req(FN_CLEANUP, 32'd0, 8'd0, 15'd4, 4'd1);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 2) add_drain();
      add_random();
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() > 0 || start || due_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(PERIOD * 400000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### sim.f
rtl/kmt_pkg.sv
rtl/kmt_ctrl.sv
rtl/kmt_dp.sv
rtl/keyed_mutex_table_top.sv
sim/keyed_mutex_table_top_tb.sv
